// ===== src/mbg_pkg.sv =====
// Shared package for the maze backtracker generator: sizes, codes, payload structs
// and the small arithmetic helper used by the sequencer.
// No dependencies.
package mbg_pkg;

    // Largest maze side the design is built for; coordinates never exceed 5 bits.
    localparam int MAX_SIDE    = 32;
    localparam int SIDE_CAP    = (MAX_SIDE < 32) ? MAX_SIDE : 32;
    localparam int COORD_W     = 5;
    localparam int ADDR_W      = 2 * COORD_W;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int COUNT_W     = ADDR_W + 1;
    localparam int SIZE_W      = 6;
    localparam int FLAGS_W     = 5;
    localparam int RND_W       = 16;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Transaction action codes.
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_STEP  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Step result kinds.
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_CARVE = 2'd1;
    localparam logic [1:0] KIND_POP   = 2'd2;

    // Directions, also the order in which neighbors are gathered.
    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    // Cell flags: bit 0 visited, bits 1..4 passages N, E, S, W.
    localparam logic [FLAGS_W-1:0] FLAG_VISITED = 5'b00001;
    localparam logic [FLAGS_W-1:0] FLAG_N       = 5'b00010;

    // Configuration register selects (APB address bit 2).
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]         action;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [RND_W-1:0]   random_value;
    } item_t;

    typedef struct packed {
        logic [COORD_W-1:0] top_x;
        logic [COORD_W-1:0] top_y;
        logic [1:0]         step_kind;
        logic [1:0]         carved_dir;
        logic               done_res;
        logic [COUNT_W-1:0] visited_count;
        logic [FLAGS_W-1:0] cell_flags;
    } result_t;

    // Effective maze size and cell count.
    typedef struct packed {
        logic [SIZE_W-1:0]  w_eff;
        logic [SIZE_W-1:0]  h_eff;
        logic [COUNT_W-1:0] area;
    } cfg_t;

    // Cell store access request.
    typedef struct packed {
        logic               en;
        logic               we;
        logic               clear;
        logic [ADDR_W-1:0]  addr;
        logic [FLAGS_W-1:0] wdata;
    } cs_cmd_t;

    // Path stack request.
    typedef struct packed {
        logic              start;
        logic              push;
        logic              pop;
        logic [ADDR_W-1:0] addr;
    } stk_cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0] depth;
        logic [ADDR_W-1:0]  top;
    } stk_stat_t;

    // Remainder by three: base-4 digits all weigh one modulo three.
    function automatic logic [1:0] mod3(input logic [RND_W-1:0] v);
        logic [4:0] s;
        logic [2:0] t;
        s = '0;
        for (int k = 0; k < RND_W / 2; k++) begin
            s = s + 5'(v[2*k +: 2]);
        end
        t = 3'(s[4]) + 3'(s[3:2]) + 3'(s[1:0]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

endpackage

// ===== src/mbg_apb_regs.sv =====
// APB configuration registers for the maze size, with the effective size and area.
// Depends on mbg_pkg.
module mbg_apb_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mbg_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mbg_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mbg_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output mbg_pkg::cfg_t                    cfg
);

    logic [mbg_pkg::SIZE_W-1:0] width_reg;
    logic [mbg_pkg::SIZE_W-1:0] height_reg;
    logic                       wr_en;
    logic                       reg_sel;
    logic [2*mbg_pkg::SIZE_W-1:0] area_full;

    // Zero acts as one, anything above the cap acts as the cap.
    function automatic logic [mbg_pkg::SIZE_W-1:0] eff_side(
        input logic [mbg_pkg::SIZE_W-1:0] r
    );
        logic [mbg_pkg::SIZE_W-1:0] e;
        e = r;
        if (r == '0) begin
            e = mbg_pkg::SIZE_W'(1);
        end else if (r > mbg_pkg::SIZE_W'(mbg_pkg::SIDE_CAP)) begin
            e = mbg_pkg::SIZE_W'(mbg_pkg::SIDE_CAP);
        end
        return e;
    endfunction

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    // Register writes complete in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mbg_pkg::SIZE_W'(8);
            height_reg <= mbg_pkg::SIZE_W'(8);
        end
        else if (wr_en)
        begin
            if (reg_sel == mbg_pkg::REG_WIDTH)
            begin
                width_reg <= pwdata[mbg_pkg::SIZE_W-1:0];
            end
            else
            begin
                height_reg <= pwdata[mbg_pkg::SIZE_W-1:0];
            end
        end
    end

    // Read data is the raw register value.
    assign prdata = (reg_sel == mbg_pkg::REG_HEIGHT) ?
                    mbg_pkg::APB_DATA_W'(height_reg) : mbg_pkg::APB_DATA_W'(width_reg);

    // Effective size and total cell count.
    always_comb
    begin
        cfg.w_eff = eff_side(width_reg);
        cfg.h_eff = eff_side(height_reg);
        area_full = (2*mbg_pkg::SIZE_W)'(cfg.w_eff) * (2*mbg_pkg::SIZE_W)'(cfg.h_eff);
        cfg.area  = area_full[mbg_pkg::COUNT_W-1:0];
    end

endmodule

// ===== src/mbg_cell_store.sv =====
// Cell flag memory, single port, registered read, with a clearing sweep.
// Depends on mbg_pkg.
module mbg_cell_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mbg_pkg::cs_cmd_t              cmd,
    output logic [mbg_pkg::FLAGS_W-1:0]   rdata,
    output logic                          clearing
);

    logic [mbg_pkg::FLAGS_W-1:0] mem [mbg_pkg::STORE_DEPTH];
    logic [mbg_pkg::FLAGS_W-1:0] rdata_reg;
    logic                        clearing_reg;
    logic                        clearing_next;
    logic [mbg_pkg::ADDR_W-1:0]  sweep_reg;
    logic [mbg_pkg::ADDR_W-1:0]  sweep_next;

    // The sweep runs once after reset and again on each clear request made while no sweep runs.
    always_comb
    begin
        clearing_next = clearing_reg;
        sweep_next    = sweep_reg;
        if (clearing_reg)
        begin
            sweep_next    = sweep_reg + 1'b1;
            clearing_next = (sweep_reg != '1);
        end
        else if (cmd.clear)
        begin
            clearing_next = 1'b1;
            sweep_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            sweep_reg    <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            sweep_reg    <= sweep_next;
        end
    end

    // One write or one read per cycle; while the sweep runs it blocks command writes, not reads.
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[sweep_reg] <= '0;
        end
        else if (cmd.en && cmd.we)
        begin
            mem[cmd.addr] <= cmd.wdata;
        end
        if (cmd.en && !cmd.we)
        begin
            rdata_reg <= mem[cmd.addr];
        end
    end

    assign rdata    = rdata_reg;
    assign clearing = clearing_reg;

endmodule

// ===== src/mbg_path_stack.sv =====
// Backtracking stack: cell address memory, depth counter and top-of-stack register.
// Depends on mbg_pkg.
module mbg_path_stack (
    input  logic                clk,
    input  logic                rst_n,
    input  mbg_pkg::stk_cmd_t   cmd,
    output mbg_pkg::stk_stat_t  stat
);

    logic [mbg_pkg::ADDR_W-1:0]  mem [mbg_pkg::STORE_DEPTH];
    logic [mbg_pkg::COUNT_W-1:0] depth_reg;
    logic [mbg_pkg::COUNT_W-1:0] depth_next;
    logic [mbg_pkg::COUNT_W-1:0] depth_m2;
    logic [mbg_pkg::ADDR_W-1:0]  top_reg;
    logic [mbg_pkg::ADDR_W-1:0]  wr_addr;

    // Depth update.
    always_comb
    begin
        depth_next = depth_reg;
        if (cmd.start)
        begin
            depth_next = mbg_pkg::COUNT_W'(1);
        end
        else if (cmd.push)
        begin
            depth_next = depth_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            depth_next = depth_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    // A pop reads the entry below the current top straight into the top register.
    assign depth_m2 = depth_reg - mbg_pkg::COUNT_W'(2);
    assign wr_addr  = cmd.start ? '0 : depth_reg[mbg_pkg::ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.start || cmd.push)
        begin
            mem[wr_addr] <= cmd.addr;
            top_reg      <= cmd.addr;
        end
        else if (cmd.pop)
        begin
            top_reg <= mem[depth_m2[mbg_pkg::ADDR_W-1:0]];
        end
    end

    assign stat.depth = depth_reg;
    assign stat.top   = top_reg;

endmodule

// ===== src/maze_backtracker_generator_unit.sv =====
// Maze backtracker generator top level: sequencer around the cell store and path stack.
// Status/no-op: reply. Read: a flag read, then reply. Pop step: gather, decide, reply.
// Carving step: gather, decide, two writes, reply (five reads and two writes through the single
// cell store port). Start: a full sweep of the 1024-entry cell store, the start write, reply.
// A new transaction is taken at the edge that takes the result; no stalls.
// After reset busy stays high while the cell store is swept clear.
module maze_backtracker_generator_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mbg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mbg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mbg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            start,
    input  mbg_pkg::item_t                  item,
    output logic                            busy,
    output logic                            result_valid,
    output mbg_pkg::result_t                result
);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_CLR      = 10'b00_0000_0010,
        ST_CLR_WAIT = 10'b00_0000_0100,
        ST_START_WR = 10'b00_0000_1000,
        ST_GATHER   = 10'b00_0001_0000,
        ST_DECIDE   = 10'b00_0010_0000,
        ST_WR_NEW   = 10'b00_0100_0000,
        ST_WR_HERE  = 10'b00_1000_0000,
        ST_RD_FLAGS = 10'b01_0000_0000,
        ST_REPLY    = 10'b10_0000_0000
    } state_t;

    mbg_pkg::cfg_t      cfg;
    mbg_pkg::cs_cmd_t   cs_cmd;
    mbg_pkg::stk_cmd_t  stk_cmd;
    mbg_pkg::stk_stat_t stk_stat;
    logic [mbg_pkg::FLAGS_W-1:0] cs_rdata;
    logic                        cs_clearing;

    state_t                       state_reg, state_next;
    logic [2:0]                   cnt_reg, cnt_next;
    logic [1:0]                   action_reg, action_next;
    logic [mbg_pkg::ADDR_W-1:0]   cur_reg, cur_next;
    logic [mbg_pkg::ADDR_W-1:0]   nb_reg, nb_next;
    logic [1:0]                   rnd3_reg, rnd3_next;
    logic [1:0]                   rnd2_reg, rnd2_next;
    logic [mbg_pkg::FLAGS_W-1:0]  top_flags_reg, top_flags_next;
    logic [3:0]                   nb_vis_reg, nb_vis_next;
    logic [1:0]                   kind_reg, kind_next;
    logic [1:0]                   dir_reg, dir_next;
    logic [mbg_pkg::COUNT_W-1:0]  visited_reg, visited_next;
    logic                         result_valid_reg, result_valid_next;
    mbg_pkg::result_t             result_reg, result_next;

    logic [mbg_pkg::COORD_W-1:0]  tx, ty;
    logic [mbg_pkg::SIZE_W-1:0]   w_m1, h_m1;
    logic [mbg_pkg::COORD_W-1:0]  sat_x, sat_y;
    logic [3:0]                   vmask, cand;
    logic [2:0]                   n_cand;
    logic [2:0]                   seen;
    logic [1:0]                   sel;
    logic [1:0]                   dir_pick;

    mbg_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mbg_cell_store u_cells (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cs_cmd),
        .rdata    (cs_rdata),
        .clearing (cs_clearing)
    );

    mbg_path_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (stk_cmd),
        .stat  (stk_stat)
    );

    // Address of the neighbor one step away in a direction, wrapping in 5 bits.
    function automatic logic [mbg_pkg::ADDR_W-1:0] step_addr(
        input logic [mbg_pkg::ADDR_W-1:0] a,
        input logic [1:0]                 d
    );
        logic [mbg_pkg::COORD_W-1:0] x;
        logic [mbg_pkg::COORD_W-1:0] y;
        x = a[mbg_pkg::COORD_W-1:0];
        y = a[mbg_pkg::ADDR_W-1:mbg_pkg::COORD_W];
        unique case (d)
            mbg_pkg::DIR_N: y = y - 1'b1;
            mbg_pkg::DIR_E: x = x + 1'b1;
            mbg_pkg::DIR_S: y = y + 1'b1;
            mbg_pkg::DIR_W: x = x - 1'b1;
        endcase
        return {y, x};
    endfunction

    assign busy = (state_reg != ST_IDLE) || cs_clearing;

    // Start cell saturated into the current maze.
    always_comb
    begin
        w_m1  = cfg.w_eff - 1'b1;
        h_m1  = cfg.h_eff - 1'b1;
        sat_x = ({1'b0, item.cell_x} > w_m1) ? w_m1[mbg_pkg::COORD_W-1:0] : item.cell_x;
        sat_y = ({1'b0, item.cell_y} > h_m1) ? h_m1[mbg_pkg::COORD_W-1:0] : item.cell_y;
    end

    // Candidate neighbors and the random pick among them.
    always_comb
    begin
        tx = cur_reg[mbg_pkg::COORD_W-1:0];
        ty = cur_reg[mbg_pkg::ADDR_W-1:mbg_pkg::COORD_W];
        vmask[mbg_pkg::DIR_N] = (ty != '0);
        vmask[mbg_pkg::DIR_E] = (({1'b0, tx} + 1'b1) < cfg.w_eff);
        vmask[mbg_pkg::DIR_S] = (({1'b0, ty} + 1'b1) < cfg.h_eff);
        vmask[mbg_pkg::DIR_W] = (tx != '0);
        cand = vmask & ~nb_vis_reg;
        n_cand = '0;
        for (int k = 0; k < 4; k++) begin
            n_cand = n_cand + 3'(cand[k]);
        end
        unique case (n_cand)
            3'd2:    sel = {1'b0, rnd2_reg[0]};
            3'd3:    sel = rnd3_reg;
            3'd4:    sel = rnd2_reg;
            default: sel = '0;
        endcase
        seen     = '0;
        dir_pick = mbg_pkg::DIR_N;
        for (int k = 0; k < 4; k++) begin
            if (cand[k])
            begin
                if (seen == {1'b0, sel})
                begin
                    dir_pick = 2'(k);
                end
                seen = seen + 1'b1;
            end
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        action_next       = action_reg;
        cur_next          = cur_reg;
        nb_next           = nb_reg;
        rnd3_next         = rnd3_reg;
        rnd2_next         = rnd2_reg;
        top_flags_next    = top_flags_reg;
        nb_vis_next       = nb_vis_reg;
        kind_next         = kind_reg;
        dir_next          = dir_reg;
        visited_next      = visited_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        cs_cmd            = '0;
        stk_cmd           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && !cs_clearing)
                begin
                    action_next = item.action;
                    kind_next   = mbg_pkg::KIND_NONE;
                    dir_next    = mbg_pkg::DIR_N;
                    cnt_next    = '0;
                    rnd3_next   = mbg_pkg::mod3(item.random_value);
                    rnd2_next   = item.random_value[1:0];
                    unique case (item.action)
                        mbg_pkg::ACT_START:
                        begin
                            cur_next   = {sat_y, sat_x};
                            state_next = ST_CLR;
                        end
                        mbg_pkg::ACT_STEP:
                        begin
                            cur_next = stk_stat.top;
                            if (visited_reg < cfg.area && stk_stat.depth != '0)
                            begin
                                state_next = ST_GATHER;
                            end
                            else
                            begin
                                state_next = ST_REPLY;
                            end
                        end
                        mbg_pkg::ACT_READ:
                        begin
                            cur_next   = {item.cell_y, item.cell_x};
                            state_next = ST_RD_FLAGS;
                        end
                        default:
                        begin
                            state_next = ST_REPLY;
                        end
                    endcase
                end
            end

            ST_CLR:
            begin
                cs_cmd.clear = 1'b1;
                state_next   = ST_CLR_WAIT;
            end

            ST_CLR_WAIT:
            begin
                if (!cs_clearing)
                begin
                    state_next = ST_START_WR;
                end
            end

            ST_START_WR:
            begin
                cs_cmd.en     = 1'b1;
                cs_cmd.we     = 1'b1;
                cs_cmd.addr   = cur_reg;
                cs_cmd.wdata  = mbg_pkg::FLAG_VISITED;
                stk_cmd.start = 1'b1;
                stk_cmd.addr  = cur_reg;
                visited_next  = mbg_pkg::COUNT_W'(1);
                state_next    = ST_REPLY;
            end

            // Reads the top cell, then N, E, S, W; data lands in the cycle after each read.
            ST_GATHER:
            begin
                if (cnt_reg < 3'd5)
                begin
                    cs_cmd.en   = 1'b1;
                    cs_cmd.addr = (cnt_reg == 3'd0) ? cur_reg :
                                  step_addr(cur_reg, 2'(cnt_reg - 3'd1));
                end
                if (cnt_reg == 3'd1)
                begin
                    top_flags_next = cs_rdata;
                end
                else if (cnt_reg != 3'd0)
                begin
                    nb_vis_next[2'(cnt_reg - 3'd2)] = cs_rdata[0];
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'd5)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (n_cand == '0)
                begin
                    stk_cmd.pop = 1'b1;
                    kind_next   = mbg_pkg::KIND_POP;
                    state_next  = ST_REPLY;
                end
                else if (stk_stat.depth < mbg_pkg::COUNT_W'(mbg_pkg::STORE_DEPTH))
                begin
                    kind_next  = mbg_pkg::KIND_CARVE;
                    dir_next   = dir_pick;
                    nb_next    = step_addr(cur_reg, dir_pick);
                    state_next = ST_WR_NEW;
                end
                else
                begin
                    state_next = ST_REPLY;
                end
            end

            // An unvisited cell holds no passages, so its new flags need no read-back.
            ST_WR_NEW:
            begin
                cs_cmd.en    = 1'b1;
                cs_cmd.we    = 1'b1;
                cs_cmd.addr  = nb_reg;
                cs_cmd.wdata = mbg_pkg::FLAG_VISITED | (mbg_pkg::FLAG_N << (dir_reg ^ 2'b10));
                stk_cmd.push = 1'b1;
                stk_cmd.addr = nb_reg;
                visited_next = visited_reg + 1'b1;
                state_next   = ST_WR_HERE;
            end

            ST_WR_HERE:
            begin
                cs_cmd.en    = 1'b1;
                cs_cmd.we    = 1'b1;
                cs_cmd.addr  = cur_reg;
                cs_cmd.wdata = top_flags_reg | (mbg_pkg::FLAG_N << dir_reg);
                state_next   = ST_REPLY;
            end

            ST_RD_FLAGS:
            begin
                cs_cmd.en   = 1'b1;
                cs_cmd.addr = cur_reg;
                state_next  = ST_REPLY;
            end

            // All state updates have landed; capture the result transaction.
            ST_REPLY:
            begin
                result_valid_next     = 1'b1;
                result_next.top_x     = (stk_stat.depth != '0) ?
                                        stk_stat.top[mbg_pkg::COORD_W-1:0] : '0;
                result_next.top_y     = (stk_stat.depth != '0) ?
                                        stk_stat.top[mbg_pkg::ADDR_W-1:mbg_pkg::COORD_W] : '0;
                result_next.step_kind = kind_reg;
                result_next.carved_dir = (kind_reg == mbg_pkg::KIND_CARVE) ? dir_reg : '0;
                result_next.done_res  = (visited_reg >= cfg.area);
                result_next.visited_count = visited_reg;
                result_next.cell_flags = (action_reg == mbg_pkg::ACT_READ) ? cs_rdata : '0;
                state_next            = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            visited_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            visited_reg      <= visited_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        action_reg    <= action_next;
        cur_reg       <= cur_next;
        nb_reg        <= nb_next;
        rnd3_reg      <= rnd3_next;
        rnd2_reg      <= rnd2_next;
        top_flags_reg <= top_flags_next;
        nb_vis_reg    <= nb_vis_next;
        kind_reg      <= kind_next;
        dir_reg       <= dir_next;
        result_reg    <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The sweep owns the cell store port.
    a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        cs_clearing |-> !cs_cmd.en)
        else $error("cell store accessed during clearing sweep");

    // A result transaction follows only the reply state.
    a_result_after_reply: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_REPLY))
        else $error("result strobe without reply state");

    // Every stacked cell was counted as visited.
    a_depth_within_visited: assert property (@(posedge clk) disable iff (!rst_n)
        stk_stat.depth <= visited_reg)
        else $error("stack depth exceeds visited count");

    // The stack never overflows.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        stk_cmd.push |-> (stk_stat.depth < mbg_pkg::COUNT_W'(mbg_pkg::STORE_DEPTH)))
        else $error("push onto a full stack");

    // The gather counter stays within its six slots.
    a_gather_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GATHER) |-> (cnt_reg <= 3'd5))
        else $error("gather counter out of range");

endmodule
